[rtl/core/ifmt_pkg.sv]
// Shared constants, types and helpers for the integer-to-ASCII formatter.
package ifmt_pkg;

	localparam int DIGIT_SLOTS      = 23;
	localparam int CHARS_PER_RESULT = 8;
	localparam int SPEC_LIMIT       = 99;
	localparam int VALUE_W          = 64;
	localparam int BCD_DIGITS       = 20;
	localparam int BCD_W            = 4 * BCD_DIGITS;
	localparam int DABBLE_STEPS     = VALUE_W / 2;
	localparam int STEP_W           = $clog2(DABBLE_STEPS);
	localparam int DC_W             = $clog2(DIGIT_SLOTS + 1);
	localparam int IDX_W            = $clog2(DIGIT_SLOTS);
	localparam int LEN_W            = 7;
	localparam int CNT_W            = 4;
	localparam int WORD_W           = 64;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;

	typedef enum logic [1:0] {
		KIND_SDEC = 2'd0,
		KIND_UDEC = 2'd1,
		KIND_OCT  = 2'd2,
		KIND_HEX  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SETUP,
		ST_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		DG_IDLE,
		DG_DABBLE,
		DG_EXTRACT,
		DG_FIX
	} dig_state_t;

	typedef enum logic [2:0] {
		EM_IDLE,
		EM_PAD_L,
		EM_PREFIX,
		EM_ZERO,
		EM_DIGIT,
		EM_PAD_R
	} em_state_t;

	// segment lengths and prefix for one formatted text
	typedef struct packed {
		logic [LEN_W-1:0] lead;
		logic [1:0]       plen;
		logic [7:0]       pre0;
		logic [7:0]       pre1;
		logic [LEN_W-1:0] zeros;
		logic [DC_W-1:0]  digits;
		logic [LEN_W-1:0] trail;
		logic [LEN_W-1:0] total;
	} emit_plan_t;

	function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
		logic [7:0] base;
		if (nib < 4'd10) begin
			base = CH_ZERO;
		end else begin
			base = (upper ? CH_UA : CH_LA) - 8'd10;
		end
		return base + {4'b0, nib};
	endfunction

endpackage

[rtl/core/ifmt_digit_unit.sv]
// Shared digit unit: binary-to-BCD double dabble for decimal kinds, then one digit per cycle into the digit store.
module ifmt_digit_unit import ifmt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [VALUE_W-1:0]  mag,
	input  logic [1:0]          kind,
	input  logic                upper,
	input  logic                extra_zero,
	input  logic [IDX_W-1:0]    rd_idx,
	output logic                done,
	output logic [DC_W-1:0]     digit_count,
	output logic [7:0]          rd_char
);

	dig_state_t         state_q, state_d;
	logic [STEP_W-1:0]  step_q;
	logic [BCD_W-1:0]   work_q;
	logic [VALUE_W-1:0] bin_q;
	logic [DC_W-1:0]    dc_q;
	kind_t              kind_q;
	logic               upper_q;
	logic [7:0]         store_q [DIGIT_SLOTS];

	logic               is_dec;
	logic               load, dabble_en, ext_en, fix_en;
	logic               we;
	logic [3:0]         nib;
	logic [7:0]         wchar;
	logic [BCD_W-1:0]   dab_a, dab_b;
	logic [BCD_W-1:0]   adj_work, adj_a;

	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] x);
		logic [BCD_W-1:0] y;
		y = x;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (x[4*d +: 4] >= 4'd5) begin
				y[4*d +: 4] = x[4*d +: 4] + 4'd3;
			end
		end
		return y;
	endfunction

	assign is_dec = (kind_t'(kind) == KIND_SDEC) || (kind_t'(kind) == KIND_UDEC);

	always_comb begin
		state_d = state_q;
		case (state_q)
			DG_IDLE: begin
				if (go) begin
					state_d = is_dec ? DG_DABBLE : DG_EXTRACT;
				end
			end
			DG_DABBLE: begin
				if (step_q == STEP_W'(DABBLE_STEPS - 1)) begin
					state_d = DG_EXTRACT;
				end
			end
			DG_EXTRACT: begin
				if (work_q == '0) begin
					state_d = DG_FIX;
				end
			end
			DG_FIX:  state_d = DG_IDLE;
			default: state_d = DG_IDLE;
		endcase
	end

	always_comb begin
		load      = 1'b0;
		dabble_en = 1'b0;
		ext_en    = 1'b0;
		fix_en    = 1'b0;
		case (state_q)
			DG_IDLE:    load      = go;
			DG_DABBLE:  dabble_en = 1'b1;
			DG_EXTRACT: ext_en    = (work_q != '0);
			DG_FIX:     fix_en    = extra_zero;
			default:    load      = 1'b0;
		endcase
	end

	assign done = (state_q == DG_FIX);

	// two binary bits per cycle
	assign adj_work = bcd_adjust(work_q);
	assign dab_a    = {adj_work[BCD_W-2:0], bin_q[VALUE_W-1]};
	assign adj_a    = bcd_adjust(dab_a);
	assign dab_b    = {adj_a[BCD_W-2:0], bin_q[VALUE_W-2]};

	assign nib   = (kind_q == KIND_OCT) ? {1'b0, work_q[2:0]} : work_q[3:0];
	assign wchar = fix_en ? CH_ZERO : digit_char(nib, upper_q && (kind_q == KIND_HEX));
	assign we    = (ext_en || fix_en) && (dc_q < DC_W'(DIGIT_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DG_IDLE;
			step_q  <= '0;
			dc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
				dc_q   <= '0;
			end else begin
				if (dabble_en) begin
					step_q <= step_q + STEP_W'(1);
				end
				if (we) begin
					dc_q <= dc_q + DC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_t'(kind);
			upper_q <= upper;
			bin_q   <= mag;
			work_q  <= is_dec ? '0 : {{(BCD_W-VALUE_W){1'b0}}, mag};
		end else if (dabble_en) begin
			bin_q  <= {bin_q[VALUE_W-3:0], 2'b00};
			work_q <= dab_b;
		end else if (ext_en) begin
			work_q <= (kind_q == KIND_OCT) ? (work_q >> 3) : (work_q >> 4);
		end
		if (we) begin
			store_q[dc_q[IDX_W-1:0]] <= wchar;
		end
	end

	assign digit_count = dc_q;
	assign rd_char     = store_q[rd_idx];

endmodule

[rtl/core/ifmt_emitter.sv]
// Character sequencer, word packer: one char per cycle in a segment, a result per word.
module ifmt_emitter import ifmt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  emit_plan_t        plan,
	input  logic [7:0]        rd_char,
	output logic [IDX_W-1:0]  rd_idx,
	output logic              idle,
	output logic              strobe,
	output logic [WORD_W-1:0] chars,
	output logic [CNT_W-1:0]  char_count,
	output logic              last
);

	em_state_t          state_q, state_d;
	logic [LEN_W-1:0]   cnt_q, rem_q, next_len, idx_full;
	logic [CNT_W-1:0]   nb_q, count_q;
	logic [WORD_W-1:0]  word_q, word_next, chars_q;
	logic               strobe_q, last_q;
	logic               emit, full, final_char, flush;
	logic [7:0]         ch;

	always_comb begin
		state_d = state_q;
		case (state_q)
			EM_IDLE:   if (go) state_d = EM_PAD_L;
			EM_PAD_L:  if (cnt_q == '0) state_d = EM_PREFIX;
			EM_PREFIX: if (cnt_q == '0) state_d = EM_ZERO;
			EM_ZERO:   if (cnt_q == '0) state_d = EM_DIGIT;
			EM_DIGIT:  if (cnt_q == '0) state_d = EM_PAD_R;
			EM_PAD_R:  if (cnt_q == '0) state_d = EM_IDLE;
			default:   state_d = EM_IDLE;
		endcase
	end

	always_comb begin
		ch       = CH_SPACE;
		next_len = '0;
		case (state_q)
			EM_PAD_L: begin
				next_len = {{(LEN_W-2){1'b0}}, plan.plen};
			end
			EM_PREFIX: begin
				ch       = (cnt_q == {{(LEN_W-2){1'b0}}, plan.plen}) ? plan.pre0 : plan.pre1;
				next_len = plan.zeros;
			end
			EM_ZERO: begin
				ch       = CH_ZERO;
				next_len = {{(LEN_W-DC_W){1'b0}}, plan.digits};
			end
			EM_DIGIT: begin
				ch       = rd_char;
				next_len = plan.trail;
			end
			default: begin
				ch       = CH_SPACE;
				next_len = '0;
			end
		endcase
	end

	assign emit       = (state_q != EM_IDLE) && (cnt_q != '0);
	assign idx_full   = cnt_q - LEN_W'(1);
	assign rd_idx     = idx_full[IDX_W-1:0];
	assign full       = (nb_q == CNT_W'(CHARS_PER_RESULT - 1));
	assign final_char = (rem_q == LEN_W'(1));
	assign flush      = emit && (full || final_char);
	assign idle       = (state_q == EM_IDLE);

	always_comb begin
		word_next = word_q;
		for (int b = 0; b < CHARS_PER_RESULT; b++) begin
			if (nb_q == CNT_W'(b)) begin
				word_next[8*b +: 8] = ch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EM_IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			nb_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			// empty text still yields one final transfer
			strobe_q <= (go && (plan.total == '0)) || flush;
			if (go) begin
				cnt_q <= plan.lead;
				rem_q <= plan.total;
				nb_q  <= '0;
			end else if (state_q != EM_IDLE) begin
				cnt_q <= (cnt_q == '0) ? next_len : cnt_q - LEN_W'(1);
			end
			if (emit) begin
				rem_q <= rem_q - LEN_W'(1);
				if (flush) begin
					nb_q <= '0;
				end else begin
					nb_q <= nb_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			word_q  <= '0;
			chars_q <= '0;
			count_q <= '0;
			last_q  <= 1'b1;
		end else if (flush) begin
			word_q  <= '0;
			chars_q <= word_next;
			count_q <= nb_q + CNT_W'(1);
			last_q  <= final_char;
		end else if (emit) begin
			word_q <= word_next;
		end
	end

	assign strobe     = strobe_q;
	assign chars      = chars_q;
	assign char_count = count_q;
	assign last       = last_q;

endmodule

[rtl/core/integer_to_ascii_formatter.sv]
// Top level of the printf-style integer-to-ASCII formatter.
//
//  channel | handshake      | payload
//  --------+----------------+--------------------------------------------------
//  command | start / busy   | value, kind, left_align, plus_sign, space_sign,
//          |                | zero_fill, alternate, upper_case, field_width,
//          |                | has_precision, precision
//  result  | strobe (1 cyc) | chars, char_count, last
//
// A command transfers on a clock edge with start high and busy low; busy then
// stays high until the last result has been shown. Results are one-cycle strobes
// with no back-pressure: the receiver must take each one as it comes.
// Decimal values go through double dabble in the shared digit unit at two bits a
// cycle, then one digit a cycle; octal and hex go straight to the digits. The
// emitter then writes the text at one character a cycle within each segment.
// Reset (arst_n low) returns all sequencers to idle; no clearing pass is needed.
module integer_to_ascii_formatter import ifmt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [VALUE_W-1:0]  value,
	input  logic [1:0]          kind,
	input  logic                left_align,
	input  logic                plus_sign,
	input  logic                space_sign,
	input  logic                zero_fill,
	input  logic                alternate,
	input  logic                upper_case,
	input  logic [LEN_W-1:0]    field_width,
	input  logic                has_precision,
	input  logic [LEN_W-1:0]    precision,
	output logic                strobe,
	output logic [WORD_W-1:0]   chars,
	output logic [CNT_W-1:0]    char_count,
	output logic                last
);

	top_state_t         state_q, state_d;

	// spec captured on the command transfer
	logic               left_q, zfill_q, hp_q, xzero_q;
	logic [LEN_W-1:0]   fw_q, pr_q;
	logic [1:0]         plen_q;
	logic [7:0]         pre0_q, pre1_q;

	logic               accept, dig_go, em_go;
	logic               negative, vzero, is_oct, oct_alt;
	logic [VALUE_W-1:0] mag;
	logic [1:0]         plen_d;
	logic [7:0]         pre0_d, pre1_d;
	logic [LEN_W-1:0]   fw_sat, pr_sat;

	logic               dig_done, em_idle;
	logic [DC_W-1:0]    dc;
	logic [IDX_W-1:0]   rd_idx;
	logic [7:0]         rd_char;

	logic [LEN_W-1:0]   dc_ext, mind, pprec, total, pad;
	emit_plan_t         plan;

	assign accept = start && !busy;

	// ---- sequencer -------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_CONV;
			ST_CONV:  if (dig_done) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_EMIT;
			ST_EMIT:  if (em_idle) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = 1'b1;
		dig_go = 1'b0;
		em_go  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				dig_go = start;
			end
			ST_SETUP: em_go = 1'b1;
			default:  busy  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- command decode --------------------------------------------------
	assign negative = (kind_t'(kind) == KIND_SDEC) && value[VALUE_W-1];
	assign mag      = negative ? (~value + VALUE_W'(1)) : value;
	assign vzero    = (value == '0);
	assign is_oct   = (kind_t'(kind) == KIND_OCT);
	assign oct_alt  = is_oct && alternate;
	assign fw_sat   = (field_width > LEN_W'(SPEC_LIMIT)) ? LEN_W'(SPEC_LIMIT) : field_width;
	assign pr_sat   = (precision > LEN_W'(SPEC_LIMIT)) ? LEN_W'(SPEC_LIMIT) : precision;

	// sign only for signed decimal; hex "0x" always lowercase and only when nonzero
	always_comb begin
		plen_d = 2'd0;
		pre0_d = CH_SPACE;
		pre1_d = CH_SPACE;
		if (kind_t'(kind) == KIND_SDEC) begin
			if (negative) begin
				plen_d = 2'd1;
				pre0_d = CH_MINUS;
			end else if (plus_sign) begin
				plen_d = 2'd1;
				pre0_d = CH_PLUS;
			end else if (space_sign) begin
				plen_d = 2'd1;
			end
		end else if ((kind_t'(kind) == KIND_HEX) && alternate && !vzero) begin
			plen_d = 2'd2;
			pre0_d = CH_ZERO;
			pre1_d = CH_LX;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= left_align;
			zfill_q <= zero_fill && !has_precision;
			hp_q    <= has_precision;
			fw_q    <= fw_sat;
			pr_q    <= pr_sat;
			plen_q  <= plen_d;
			pre0_q  <= pre0_d;
			pre1_q  <= pre1_d;
			// zero value with precision 0 prints nothing, unless octal alternate;
			// octal alternate otherwise adds one leading zero digit
			xzero_q <= vzero ? (!has_precision || (pr_sat != '0) || oct_alt) : oct_alt;
		end
	end

	// ---- layout of the text (valid once the digit count has settled) ----
	assign dc_ext = {{(LEN_W-DC_W){1'b0}}, dc};
	assign mind   = (hp_q && (pr_q > dc_ext)) ? pr_q : dc_ext;
	assign pprec  = mind + {{(LEN_W-2){1'b0}}, plen_q};
	assign total  = (fw_q > pprec) ? fw_q : pprec;
	assign pad    = total - pprec;

	always_comb begin
		plan        = '0;
		plan.lead   = (!left_q && !zfill_q) ? pad : '0;
		plan.plen   = plen_q;
		plan.pre0   = pre0_q;
		plan.pre1   = pre1_q;
		plan.zeros  = (mind - dc_ext) + ((!left_q && zfill_q) ? pad : '0);
		plan.digits = dc;
		plan.trail  = left_q ? pad : '0;
		plan.total  = total;
	end

	// ---- datapath units --------------------------------------------------
	ifmt_digit_unit u_digits (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (dig_go),
		.mag         (mag),
		.kind        (kind),
		.upper       (upper_case),
		.extra_zero  (xzero_q),
		.rd_idx      (rd_idx),
		.done        (dig_done),
		.digit_count (dc),
		.rd_char     (rd_char)
	);

	ifmt_emitter u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (em_go),
		.plan       (plan),
		.rd_char    (rd_char),
		.rd_idx     (rd_idx),
		.idle       (em_idle),
		.strobe     (strobe),
		.chars      (chars),
		.char_count (char_count),
		.last       (last)
	);

endmodule

[rtl/core/ifmt_checker.sv]
// Port-level checker for the formatter, bound to the top level.
module ifmt_checker import ifmt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic [CNT_W-1:0]  char_count,
	input logic              last
);

	// results appear only inside a command's busy window
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result transfer outside busy window");

	a_full_beats: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> char_count == CNT_W'(CHARS_PER_RESULT))
		else $error("non-final result not full");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> char_count <= CNT_W'(CHARS_PER_RESULT))
		else $error("char_count above word size");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && char_count == '0 |-> last)
		else $error("empty result not final");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after command transfer");

endmodule

bind integer_to_ascii_formatter ifmt_checker u_ifmt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.char_count (char_count),
	.last       (last)
);

[tb/tb_integer_to_ascii_formatter.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the integer-to-ASCII formatter: directed and random format commands.
module tb_integer_to_ascii_formatter import ifmt_pkg::*; ;

	// Flag masks for building commands: left, plus, space, zero, alternate, upper.
	localparam logic [5:0] FL_LEFT  = 6'b100000;
	localparam logic [5:0] FL_PLUS  = 6'b010000;
	localparam logic [5:0] FL_SPACE = 6'b001000;
	localparam logic [5:0] FL_ZERO  = 6'b000100;
	localparam logic [5:0] FL_ALT   = 6'b000010;
	localparam logic [5:0] FL_UPPER = 6'b000001;

	localparam int RANDOM_COMMANDS = 400;
	localparam int GAP_PERCENT     = 24;
	localparam int TAIL_CYCLES     = 300;
	localparam int DRAIN_LIMIT     = 50000;

	// One format command, as it goes over the command port.
	typedef struct {
		logic [VALUE_W-1:0] value;
		kind_t              kind;
		logic               left_align;
		logic               plus_sign;
		logic               space_sign;
		logic               zero_fill;
		logic               alternate;
		logic               upper_case;
		logic [LEN_W-1:0]   field_width;
		logic               has_precision;
		logic [LEN_W-1:0]   precision;
	} fmt_cmd_t;

	// One output beat: up to eight characters, low byte first.
	typedef struct {
		logic [WORD_W-1:0] chars;
		logic [CNT_W-1:0]  count;
		logic              last;
	} text_beat_t;

	// Formats each accepted command into text and holds the beats still due.
	class fmt_scoreboard;
		text_beat_t text_beats[$];
		int         errors;
		int         commands;
		int         kind_seen[4];
		int         beats_checked;
		int         empty_texts;
		int         longest_text;

		function int pending();
			return text_beats.size();
		endfunction

		// Work out the printf-style text of one command and queue its beats.
		function void record_command(fmt_cmd_t c);
			logic [VALUE_W-1:0] mag;
			byte unsigned       digs[$];
			byte unsigned       prefix[$];
			byte unsigned       text[$];
			string              hex_tab;
			logic               zero;
			int                 fw;
			int                 pr;
			int                 mind;
			int                 pprec;
			int                 nbeats;
			int                 cnt;
			text_beat_t         b;

			fw = (c.field_width > SPEC_LIMIT) ? SPEC_LIMIT : int'(c.field_width);
			pr = (c.precision > SPEC_LIMIT) ? SPEC_LIMIT : int'(c.precision);
			mag = c.value;
			hex_tab = c.upper_case ? "0123456789ABCDEF" : "0123456789abcdef";

			// sign prefix only for signed decimal; minus wins, then plus, then space
			if (c.kind == KIND_SDEC) begin
				if (mag[VALUE_W-1]) begin
					mag = -mag;
					prefix.push_back(CH_MINUS);
				end else if (c.plus_sign) begin
					prefix.push_back(CH_PLUS);
				end else if (c.space_sign) begin
					prefix.push_back(CH_SPACE);
				end
			end
			zero = c.zero_fill && !c.has_precision;

			// digits, least significant first
			if (mag == 0) begin
				if (!c.has_precision || pr != 0 || (c.kind == KIND_OCT && c.alternate))
					digs.push_back(CH_ZERO);
			end else if (c.kind == KIND_SDEC || c.kind == KIND_UDEC) begin
				while (mag != 0) begin
					digs.push_back(CH_ZERO + 8'(mag % 10));
					mag = mag / 10;
				end
			end else if (c.kind == KIND_HEX) begin
				while (mag != 0) begin
					digs.push_back(hex_tab[mag[3:0]]);
					mag = mag >> 4;
				end
				// 0x stays lowercase even with upper case digits
				if (c.alternate) begin
					prefix.delete();
					prefix.push_back(CH_ZERO);
					prefix.push_back(CH_LX);
				end
			end else begin
				while (mag != 0) begin
					digs.push_back(CH_ZERO + {5'd0, mag[2:0]});
					mag = mag >> 3;
				end
				if (c.alternate)
					digs.push_back(CH_ZERO);
			end

			mind = (c.has_precision && pr > digs.size()) ? pr : digs.size();
			pprec = mind + prefix.size();

			if (!c.left_align && !zero)
				for (int i = pprec; i < fw; i++) text.push_back(CH_SPACE);
			foreach (prefix[i]) text.push_back(prefix[i]);
			if (!c.left_align && zero)
				for (int i = pprec; i < fw; i++) text.push_back(CH_ZERO);
			for (int i = digs.size(); i < mind; i++) text.push_back(CH_ZERO);
			for (int i = digs.size() - 1; i >= 0; i--) text.push_back(digs[i]);
			if (c.left_align)
				for (int i = pprec; i < fw; i++) text.push_back(CH_SPACE);

			// an empty text still gives one beat, count 0
			nbeats = (text.size() == 0) ? 1 :
				(text.size() + CHARS_PER_RESULT - 1) / CHARS_PER_RESULT;
			for (int r = 0; r < nbeats; r++) begin
				b.chars = '0;
				cnt = 0;
				while (cnt < CHARS_PER_RESULT && r * CHARS_PER_RESULT + cnt < text.size()) begin
					b.chars = b.chars |
						(WORD_W'(text[r * CHARS_PER_RESULT + cnt]) << (8 * cnt));
					cnt++;
				end
				b.count = CNT_W'(cnt);
				b.last = (r == nbeats - 1);
				text_beats.push_back(b);
			end

			commands++;
			kind_seen[c.kind]++;
			if (text.size() == 0) empty_texts++;
			if (text.size() > longest_text) longest_text = text.size();
		endfunction

		// Compare one strobed beat with the oldest one due.
		function void check_beat(logic [WORD_W-1:0] got_chars, logic [CNT_W-1:0] got_count,
				logic got_last);
			text_beat_t b;
			if (text_beats.size() == 0) begin
				$display("%0t ns: beat with none due: chars %h count %0d last %b",
					$time, got_chars, got_count, got_last);
				errors++;
				return;
			end
			b = text_beats.pop_front();
			beats_checked++;
			if (got_chars !== b.chars) begin
				$display("%0t ns: chars mismatch: expected %h actual %h",
					$time, b.chars, got_chars);
				errors++;
			end
			if (got_count !== b.count) begin
				$display("%0t ns: char_count mismatch: expected %0d actual %0d",
					$time, b.count, got_count);
				errors++;
			end
			if (got_last !== b.last) begin
				$display("%0t ns: last mismatch: expected %b actual %b",
					$time, b.last, got_last);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [VALUE_W-1:0]  value;
	logic [1:0]          kind;
	logic                left_align;
	logic                plus_sign;
	logic                space_sign;
	logic                zero_fill;
	logic                alternate;
	logic                upper_case;
	logic [LEN_W-1:0]    field_width;
	logic                has_precision;
	logic [LEN_W-1:0]    precision;
	logic                strobe;
	logic [WORD_W-1:0]   chars;
	logic [CNT_W-1:0]    char_count;
	logic                last;

	fmt_scoreboard sb = new();
	bit            allow_gaps;

	integer_to_ascii_formatter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.kind          (kind),
		.left_align    (left_align),
		.plus_sign     (plus_sign),
		.space_sign    (space_sign),
		.zero_fill     (zero_fill),
		.alternate     (alternate),
		.upper_case    (upper_case),
		.field_width   (field_width),
		.has_precision (has_precision),
		.precision     (precision),
		.strobe        (strobe),
		.chars         (chars),
		.char_count    (char_count),
		.last          (last)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results can't be held off: every strobed beat is checked at the edge ending it.
	// Reading in the active region sees the pre-edge values the edge captures.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1)
			sb.check_beat(chars, char_count, last);
	end

	function automatic fmt_cmd_t cmd_of(logic [VALUE_W-1:0] v, kind_t k, logic [5:0] flags,
			logic [LEN_W-1:0] fw, logic hp, logic [LEN_W-1:0] pr);
		fmt_cmd_t c;
		c.value         = v;
		c.kind          = k;
		c.left_align    = flags[5];
		c.plus_sign     = flags[4];
		c.space_sign    = flags[3];
		c.zero_fill     = flags[2];
		c.alternate     = flags[1];
		c.upper_case    = flags[0];
		c.field_width   = fw;
		c.has_precision = hp;
		c.precision     = pr;
		return c;
	endfunction

	// Mostly small widths and precisions; now and then up to the 7-bit top, which
	// also hits the saturation at 99.
	function automatic logic [LEN_W-1:0] random_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) return LEN_W'($urandom_range(0, 16));
		if (sel < 90) return LEN_W'($urandom_range(0, 40));
		return LEN_W'($urandom_range(0, 127));
	endfunction

	function automatic fmt_cmd_t random_cmd();
		fmt_cmd_t c;
		logic [VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = VALUE_W'($urandom_range(0, 20));
			2: v = '1;
			3: v = VALUE_W'(1) << $urandom_range(0, 63);
			4: v = {1'b1, {(VALUE_W-1){1'b0}}};
			5: v = -VALUE_W'($urandom_range(1, 1000));
			6: v = v >> $urandom_range(0, 63);
			default: ;
		endcase
		c = cmd_of(v, kind_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
			random_len(), 1'($urandom_range(0, 1)), random_len());
		return c;
	endfunction

	// Called at a clock edge; returns at the edge where the command transfers.
	// start is never lowered and raised in the same time step.
	task automatic send_command(fmt_cmd_t c);
		while (allow_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		value         <= c.value;
		kind          <= c.kind;
		left_align    <= c.left_align;
		plus_sign     <= c.plus_sign;
		space_sign    <= c.space_sign;
		zero_fill     <= c.zero_fill;
		alternate     <= c.alternate;
		upper_case    <= c.upper_case;
		field_width   <= c.field_width;
		has_precision <= c.has_precision;
		precision     <= c.precision;
		do @(posedge clk); while (busy !== 1'b0);
		sb.record_command(c);
	endtask

	// Hold off the sender until every beat due has come out.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		int waited;

		arst_n        <= 1'b0;
		start         <= 1'b0;
		value         <= '0;
		kind          <= KIND_SDEC;
		left_align    <= 1'b0;
		plus_sign     <= 1'b0;
		space_sign    <= 1'b0;
		zero_fill     <= 1'b0;
		alternate     <= 1'b0;
		upper_case    <= 1'b0;
		field_width   <= '0;
		has_precision <= 1'b0;
		precision     <= '0;
		allow_gaps    = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each kind, each flag and the corner cases
		send_command(cmd_of('0, KIND_SDEC, '0, 0, 0, 0));
		send_command(cmd_of('1, KIND_SDEC, '0, 0, 0, 0));
		// most negative value prints its full magnitude
		send_command(cmd_of({1'b1, {(VALUE_W-1){1'b0}}}, KIND_SDEC, '0, 25, 0, 0));
		send_command(cmd_of({1'b0, {(VALUE_W-1){1'b1}}}, KIND_SDEC, FL_PLUS, 0, 0, 0));
		send_command(cmd_of(42, KIND_SDEC, FL_SPACE, 6, 0, 0));
		// plus beats space
		send_command(cmd_of(42, KIND_SDEC, FL_PLUS | FL_SPACE, 0, 0, 0));
		send_command(cmd_of('1, KIND_UDEC, FL_LEFT, 99, 0, 0));
		// longest digit string: 22 octal digits plus the alternate zero
		send_command(cmd_of('1, KIND_OCT, FL_ALT, 0, 0, 0));
		// zero at precision 0: octal alternate still gives one digit
		send_command(cmd_of('0, KIND_OCT, FL_ALT, 0, 1, 0));
		// zero at precision 0: empty text
		send_command(cmd_of('0, KIND_UDEC, '0, 0, 1, 0));
		send_command(cmd_of('0, KIND_HEX, FL_ALT, 0, 1, 0));
		// hex alternate on zero: no 0x
		send_command(cmd_of('0, KIND_HEX, FL_ALT | FL_UPPER, 4, 0, 0));
		// 0x stays lowercase with capital digits
		send_command(cmd_of(64'hdead_beef, KIND_HEX, FL_ALT | FL_UPPER, 0, 0, 0));
		send_command(cmd_of(64'hff, KIND_HEX, FL_ALT | FL_ZERO, 10, 0, 0));
		send_command(cmd_of(-64'd5, KIND_SDEC, FL_ZERO, 8, 0, 0));
		// left wins over zero fill
		send_command(cmd_of(123, KIND_UDEC, FL_LEFT | FL_ZERO, 8, 0, 0));
		// a precision turns zero fill off
		send_command(cmd_of(7, KIND_SDEC, FL_ZERO, 10, 1, 5));
		// width and precision above 99 saturate
		send_command(cmd_of('1, KIND_HEX, FL_UPPER, 127, 1, 127));
		send_command(cmd_of(-64'd9, KIND_SDEC, FL_PLUS, 0, 1, 120));
		send_command(cmd_of(8, KIND_OCT, FL_ALT, 0, 1, 5));
		// flags that do not apply to the kind are ignored
		send_command(cmd_of(77, KIND_UDEC, FL_PLUS | FL_SPACE | FL_ALT | FL_UPPER, 0, 0, 0));
		send_command(cmd_of(64'h1234_5678_9abc_def0, KIND_HEX, '0, 1, 0, 0));
		send_command(cmd_of('0, KIND_SDEC, FL_PLUS, 3, 1, 0));
		send_command(cmd_of(64'o777, KIND_OCT, FL_ALT | FL_LEFT, 12, 0, 0));
		send_command(cmd_of('1, KIND_SDEC, FL_ZERO | FL_SPACE, 127, 0, 0));

		drain_results();

		// random: a stretch in the middle with no sender gaps, and a full drain every
		// hundred commands
		for (int n = 0; n < RANDOM_COMMANDS; n++) begin
			allow_gaps = !(n >= 150 && n < 250);
			if (n % 100 == 99)
				drain_results();
			send_command(random_cmd());
		end
		start <= 1'b0;

		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		// stray beats after the last one due would show up here
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t ns: %0d beats still due at the end", $time, sb.pending());
			sb.errors++;
		end

		$display("Formatted %0d commands (sdec %0d, udec %0d, oct %0d, hex %0d).",
			sb.commands, sb.kind_seen[KIND_SDEC], sb.kind_seen[KIND_UDEC],
			sb.kind_seen[KIND_OCT], sb.kind_seen[KIND_HEX]);
		$display("Checked %0d beats, %0d empty texts, longest text %0d chars, %0d errors.",
			sb.beats_checked, sb.empty_texts, sb.longest_text, sb.errors);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#5ms;
		$display("%0t ns: timeout", $time);
		$display("== FAIL ==");
		$finish;
	end

endmodule
